/* hdl/tsw_pkg.sv */
// tsw_pkg: shared types and codes for the TCP sender window / retransmission block.
// Holds the channel payload structs, the controller states and the command/status structs.
// No dependencies.
`default_nettype none

package tsw_pkg;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2,
        OP_EMPTY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_ISN      = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_MAX_PAY  = 2'd2,
        CFG_CAPACITY = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
    localparam logic [15:0] MAX_PAY_RESET  = 16'd1000;
    localparam logic [20:0] CAPACITY_RESET = 21'd65536;

    typedef struct packed {
        logic [1:0]  operation;
        logic [20:0] bytes_added;
        logic        stream_ended;
        logic [31:0] ack_number;
        logic [15:0] peer_window;
        logic [15:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic        segment_valid;
        logic [31:0] segment_seqno;
        logic [15:0] payload_length;
        logic        syn_bit;
        logic        fin_bit;
        logic        is_retransmit;
        logic        ack_accepted;
        logic [7:0]  retx_count;
        logic [31:0] in_flight;
        logic        ring_full;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [63:0] seq;
        logic [15:0] len;
        logic        syn;
        logic        fin;
    } ring_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL_BUF,
        S_ACK_D,
        S_ACK_A,
        S_ACK_CHK,
        S_POP_RD,
        S_POP_CHK,
        S_FILL_START,
        S_FILL_STEP,
        S_FILL_END,
        S_TICK,
        S_OUT_SETUP,
        S_OUT_RD,
        S_OUT_LOAD,
        S_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic fill_buf;
        logic ack_d;
        logic ack_a;
        logic ack_chk;
        logic pop_chk;
        logic fill_start;
        logic fill_step;
        logic ack_finish;
        logic tick;
        logic out_setup;
        logic out_load;
        logic out_next;
        logic out_done;
        logic rd_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       ack_new;
        logic       ring_empty;
        logic       pop_ok;
        logic       syn_pending;
        logic       step_go;
        logic       last;
    } stat_t;

endpackage

`default_nettype wire

/* hdl/tcp_sender_window_retx.sv */
// tcp_sender_window_retx: top level of the TCP sender window / retransmission block.
// Instantiates tsw_ctrl and tsw_datapath; uses tsw_pkg.
//
//   channel   signals                              moves
//   item      item_valid / item_stall / item       one command transaction in
//   result    result_valid / result_stall / result segment descriptors out, last_result ends
//   config    cfg_write / cfg_index / cfg_data     register write, taken on any edge
//
// One item at a time, loaded in the accepting cycle. Ack: the D, A and check states, then
// for a new ack a head read and a head check per popped segment and a window fill; fill
// item: a buffer update, then a window fill. Window fill: a start state that writes any SYN,
// a step per emitted data or FIN segment and an end state; tick: the tick state. Then an
// output setup and, per result, a read, a load and a wait while result_stall is high.
// item_stall is high whenever an item is in progress. Reset is asynchronous; no clearing pass.
`default_nettype none

module tcp_sender_window_retx
    import tsw_pkg::*;
#(
    parameter int RING_DEPTH = 32,
    parameter int MAX_SEGS   = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result
);

    cmd_t  cmd;
    stat_t stat;

    tsw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_op      (item.operation),
        .item_stall   (item_stall),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    tsw_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_SEGS   (MAX_SEGS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

/* hdl/tsw_ctrl.sv */
// tsw_ctrl: sequencing state machine for the TCP sender block.
// Drives datapath commands from handshakes and datapath status. Uses tsw_pkg.
`default_nettype none

module tsw_ctrl
    import tsw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic [1:0] item_op,
    output logic            item_stall,
    input  wire logic       result_stall,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (item_op)
                        OP_FILL:  state_next = S_FILL_BUF;
                        OP_ACK:   state_next = S_ACK_D;
                        OP_TICK:  state_next = S_TICK;
                        default:  state_next = S_OUT_SETUP;
                    endcase
                end
            end
            S_FILL_BUF:
            begin
                cmd.fill_buf = 1'b1;
                state_next   = S_FILL_START;
            end
            S_ACK_D:
            begin
                cmd.ack_d  = 1'b1;
                state_next = S_ACK_A;
            end
            S_ACK_A:
            begin
                cmd.ack_a  = 1'b1;
                state_next = S_ACK_CHK;
            end
            S_ACK_CHK:
            begin
                cmd.ack_chk = 1'b1;
                state_next  = stat.ack_new ? S_POP_RD : S_OUT_SETUP;
            end
            S_POP_RD:
            begin
                // ring head is read this cycle, checked next
                state_next = stat.ring_empty ? S_FILL_START : S_POP_CHK;
            end
            S_POP_CHK:
            begin
                cmd.pop_chk = 1'b1;
                state_next  = stat.pop_ok ? S_POP_RD : S_FILL_START;
            end
            S_FILL_START:
            begin
                cmd.fill_start = 1'b1;
                state_next     = stat.syn_pending ? S_FILL_END : S_FILL_STEP;
            end
            S_FILL_STEP:
            begin
                cmd.fill_step = 1'b1;
                state_next    = stat.step_go ? S_FILL_STEP : S_FILL_END;
            end
            S_FILL_END:
            begin
                cmd.ack_finish = (stat.op == OP_ACK);
                state_next     = S_OUT_SETUP;
            end
            S_TICK:
            begin
                cmd.tick   = 1'b1;
                state_next = S_OUT_SETUP;
            end
            S_OUT_SETUP:
            begin
                cmd.out_setup = 1'b1;
                state_next    = S_OUT_RD;
            end
            S_OUT_RD:
            begin
                cmd.rd_out = 1'b1;
                state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (!result_stall)
                begin
                    if (stat.last)
                    begin
                        cmd.out_done = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/tsw_datapath.sv */
// tsw_datapath: sender state, configuration registers, outstanding-segment ring and result register.
// Acts on commands from tsw_ctrl and returns status. Uses tsw_pkg.
`default_nettype none

module tsw_datapath
    import tsw_pkg::*;
#(
    parameter int RING_DEPTH = 32,
    parameter int MAX_SEGS   = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire item_t       item,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    output logic             result_valid,
    output result_t          result
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int NW = $clog2(MAX_SEGS + 1);

    // configuration
    logic [31:0] isn_reg;
    logic [15:0] init_to_reg;
    logic [15:0] max_pay_reg;
    logic [20:0] cap_reg;

    // sender state
    logic [63:0] next_reg;
    logic [63:0] acked_reg;
    logic [15:0] win_reg;
    logic [20:0] buf_reg;
    logic        closed_reg;
    logic        syn_sent_reg;
    logic        fin_sent_reg;
    logic [31:0] timer_reg;
    logic [31:0] cur_to_reg;
    logic        running_reg;
    logic [7:0]  retx_reg;
    logic [IW-1:0] head_reg;
    logic [CW-1:0] count_reg;

    // per-transaction work registers
    item_t       item_reg;
    logic        accepted_reg;
    logic        full_reg;
    logic        retx_item_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] left_reg;
    logic [IW-1:0] start_reg;
    logic [IW-1:0] optr_reg;
    logic [31:0] d_reg;
    logic [63:0] a_reg;
    logic [16:0] remain_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    // ring memory
    ring_entry_t ring [RING_DEPTH];
    ring_entry_t rdata_reg;
    ring_entry_t wdata;
    logic        mem_we;
    logic [IW-1:0] raddr;

    // tail = (head + count) mod depth
    logic [CW:0]   tail_sum;
    logic [CW:0]   tail_wrap;
    logic [IW-1:0] tail;

    assign tail_sum  = {{(CW + 1 - IW){1'b0}}, head_reg} + {1'b0, count_reg};
    assign tail_wrap = tail_sum - (CW + 1)'(RING_DEPTH);
    assign tail      = (tail_sum >= (CW + 1)'(RING_DEPTH)) ? tail_wrap[IW-1:0]
                                                           : tail_sum[IW-1:0];

    logic can_n;
    logic ring_room;
    assign can_n     = (n_reg < NW'(MAX_SEGS));
    assign ring_room = (count_reg < CW'(RING_DEPTH));

    logic [IW-1:0] head_inc;
    logic [IW-1:0] optr_inc;
    assign head_inc = (head_reg == IW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign optr_inc = (optr_reg == IW'(RING_DEPTH - 1)) ? '0 : optr_reg + 1'b1;

    // ack unwrapping
    logic [31:0] d_calc;
    logic [32:0] back;
    logic [63:0] back64;
    logic [63:0] a_calc;
    assign d_calc = item_reg.ack_number - (acked_reg[31:0] + isn_reg);
    assign back   = 33'h1_0000_0000 - {1'b0, d_reg};
    assign back64 = {31'b0, back};
    assign a_calc = (d_reg[31] && (acked_reg >= back64)) ? acked_reg - back64
                                                         : acked_reg + {32'b0, d_reg};

    logic ack_bad;
    logic ack_new;
    assign ack_bad = (a_reg > next_reg);
    assign ack_new = !ack_bad && (a_reg >= acked_reg);

    logic [63:0] seg_end;
    assign seg_end = rdata_reg.seq + {48'b0, rdata_reg.len}
                   + {63'b0, rdata_reg.syn} + {63'b0, rdata_reg.fin};

    // window remaining at fill start
    logic [15:0] win1;
    logic [63:0] limit;
    logic [63:0] rem_diff;
    assign win1     = (win_reg == 16'd0) ? 16'd1 : win_reg;
    assign limit    = acked_reg + {48'b0, win1};
    assign rem_diff = limit - next_reg;

    // one fill iteration
    logic [16:0] want;
    logic [16:0] take;
    logic        step_fin;
    logic        step_live;
    logic        step_go;
    assign want      = (remain_reg < {1'b0, max_pay_reg}) ? remain_reg : {1'b0, max_pay_reg};
    assign take      = ({4'b0, want} < buf_reg) ? want : buf_reg[16:0];
    assign step_fin  = (take < want) && closed_reg;
    assign step_live = (remain_reg != 17'd0) && !fin_sent_reg && can_n;
    assign step_go   = step_live && ring_room && !((take == 17'd0) && !step_fin);

    logic syn_go;
    assign syn_go = !syn_sent_reg && can_n && ring_room;

    // timer
    logic [32:0] t_sum;
    logic [31:0] t_sat;
    assign t_sum = {1'b0, timer_reg} + {17'b0, item_reg.elapsed_ms};
    assign t_sat = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];

    always_comb
    begin
        mem_we = 1'b0;
        wdata  = '{seq: next_reg, len: take[15:0], syn: 1'b0, fin: step_fin};
        if (cmd.fill_start && syn_go)
        begin
            mem_we = 1'b1;
            wdata  = '{seq: next_reg, len: 16'd0, syn: 1'b1, fin: 1'b0};
        end
        else if (cmd.fill_step && step_go)
        begin
            mem_we = 1'b1;
        end
    end

    assign raddr = cmd.rd_out ? optr_reg : head_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring[tail] <= wdata;
        end
        rdata_reg <= ring[raddr];
    end

    always_comb
    begin
        stat.op          = item_reg.operation;
        stat.ack_new     = ack_new;
        stat.ring_empty  = (count_reg == '0);
        stat.pop_ok      = (seg_end <= a_reg);
        stat.syn_pending = !syn_sent_reg;
        stat.step_go     = step_go;
        stat.last        = (left_reg == '0);
    end

    // payload-only work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.ack_d)
        begin
            d_reg <= d_calc;
        end
        if (cmd.ack_a)
        begin
            a_reg <= a_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isn_reg       <= '0;
            init_to_reg   <= TIMEOUT_RESET;
            max_pay_reg   <= MAX_PAY_RESET;
            cap_reg       <= CAPACITY_RESET;
            next_reg      <= '0;
            acked_reg     <= '0;
            win_reg       <= 16'd1;
            buf_reg       <= '0;
            closed_reg    <= 1'b0;
            syn_sent_reg  <= 1'b0;
            fin_sent_reg  <= 1'b0;
            timer_reg     <= '0;
            cur_to_reg    <= {16'b0, TIMEOUT_RESET};
            running_reg   <= 1'b0;
            retx_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            accepted_reg  <= 1'b1;
            full_reg      <= 1'b0;
            retx_item_reg <= 1'b0;
            n_reg         <= '0;
            left_reg      <= '0;
            start_reg     <= '0;
            optr_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ISN:     isn_reg <= cfg_data;
                    CFG_TIMEOUT:
                    begin
                        init_to_reg <= cfg_data[15:0];
                        cur_to_reg  <= {16'b0, cfg_data[15:0]};
                    end
                    CFG_MAX_PAY: max_pay_reg <= cfg_data[15:0];
                    default:     cap_reg <= cfg_data[20:0];
                endcase
            end

            if (cmd.load_item)
            begin
                accepted_reg  <= 1'b1;
                full_reg      <= 1'b0;
                retx_item_reg <= 1'b0;
                n_reg         <= '0;
            end

            if (cmd.fill_buf)
            begin
                if ({1'b0, buf_reg} + {1'b0, item_reg.bytes_added} < {1'b0, cap_reg})
                begin
                    buf_reg <= buf_reg + item_reg.bytes_added;
                end
                else
                begin
                    buf_reg <= cap_reg;
                end
                if (item_reg.stream_ended)
                begin
                    closed_reg <= 1'b1;
                end
            end

            if (cmd.ack_chk)
            begin
                if (ack_bad)
                begin
                    accepted_reg <= 1'b0;
                end
                else if (ack_new)
                begin
                    acked_reg <= a_reg;
                    win_reg   <= item_reg.peer_window;
                end
            end

            if (cmd.pop_chk && (seg_end <= a_reg))
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.fill_start)
            begin
                start_reg <= tail;
                if (!syn_sent_reg)
                begin
                    if (syn_go)
                    begin
                        syn_sent_reg <= 1'b1;
                        count_reg    <= count_reg + 1'b1;
                        n_reg        <= n_reg + 1'b1;
                        next_reg     <= next_reg + 64'd1;
                        if (!running_reg)
                        begin
                            running_reg <= 1'b1;
                            timer_reg   <= '0;
                        end
                    end
                    else if (can_n)
                    begin
                        full_reg <= 1'b1;
                    end
                end
                else
                begin
                    remain_reg <= (limit > next_reg) ? rem_diff[16:0] : 17'd0;
                end
            end

            if (cmd.fill_step)
            begin
                if (step_live && !ring_room)
                begin
                    full_reg <= 1'b1;
                end
                if (step_go)
                begin
                    buf_reg    <= buf_reg - {4'b0, take};
                    next_reg   <= next_reg + {47'b0, take} + {63'b0, step_fin};
                    remain_reg <= remain_reg - take - {16'b0, step_fin};
                    count_reg  <= count_reg + 1'b1;
                    n_reg      <= n_reg + 1'b1;
                    if (step_fin)
                    begin
                        fin_sent_reg <= 1'b1;
                    end
                    if (!running_reg)
                    begin
                        running_reg <= 1'b1;
                        timer_reg   <= '0;
                    end
                end
            end

            if (cmd.ack_finish)
            begin
                cur_to_reg  <= {16'b0, init_to_reg};
                retx_reg    <= '0;
                running_reg <= (count_reg != '0);
                timer_reg   <= '0;
            end

            if (cmd.tick && running_reg)
            begin
                if (t_sat >= cur_to_reg)
                begin
                    timer_reg <= '0;
                    if (count_reg != '0)
                    begin
                        retx_item_reg <= 1'b1;
                        n_reg         <= NW'(1);
                        // zero window probe: resend without backoff
                        if (win_reg != 16'd0)
                        begin
                            if (retx_reg != 8'hFF)
                            begin
                                retx_reg <= retx_reg + 8'd1;
                            end
                            cur_to_reg <= cur_to_reg[31] ? 32'hFFFF_FFFF
                                                         : {cur_to_reg[30:0], 1'b0};
                        end
                    end
                    else
                    begin
                        running_reg <= 1'b0;
                    end
                end
                else
                begin
                    timer_reg <= t_sat;
                end
            end

            if (cmd.out_setup)
            begin
                optr_reg <= retx_item_reg ? head_reg : start_reg;
                left_reg <= (n_reg == '0) ? '0 : n_reg - 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg         <= 1'b1;
                out_reg.ack_accepted  <= accepted_reg;
                out_reg.retx_count    <= retx_reg;
                out_reg.in_flight     <= next_reg[31:0] - acked_reg[31:0];
                out_reg.ring_full     <= full_reg;
                out_reg.last_result   <= (left_reg == '0);
                out_reg.is_retransmit <= retx_item_reg;
                if (n_reg != '0)
                begin
                    out_reg.segment_valid  <= 1'b1;
                    out_reg.segment_seqno  <= rdata_reg.seq[31:0] + isn_reg;
                    out_reg.payload_length <= rdata_reg.len;
                    out_reg.syn_bit        <= rdata_reg.syn;
                    out_reg.fin_bit        <= rdata_reg.fin;
                end
                else
                begin
                    out_reg.segment_valid  <= (item_reg.operation == OP_EMPTY);
                    out_reg.segment_seqno  <= (item_reg.operation == OP_EMPTY)
                                              ? next_reg[31:0] + isn_reg : 32'd0;
                    out_reg.payload_length <= '0;
                    out_reg.syn_bit        <= 1'b0;
                    out_reg.fin_bit        <= 1'b0;
                end
            end

            if (cmd.out_next)
            begin
                out_valid_reg <= 1'b0;
                optr_reg      <= optr_inc;
                left_reg      <= left_reg - 1'b1;
            end

            if (cmd.out_done)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
